### hdl/particle_euler_step_with_plane_bounce_macros.svh
// ============================================================================
// Assertion macros for the particle Euler step block
// Short forms for concurrent assertions clocked by clk_i and disabled while
// rst_ni is low.
// ============================================================================
`ifndef PARTICLE_EULER_STEP_WITH_PLANE_BOUNCE_MACROS_SVH
`define PARTICLE_EULER_STEP_WITH_PLANE_BOUNCE_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define PES_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define PES_ASSERT_NEVER(name, cond, msg) \
  `PES_ASSERT(name, !(cond), msg)

`endif

### hdl/pes_pkg.sv
// ============================================================================
// Particle Euler step package
// Shared types, register codes, pipeline stage positions and fixed-point
// helper functions.
// ============================================================================
package pes_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [17:0] norm_t;
  typedef logic signed [49:0] prod_t;

  localparam int unsigned NumStages = 11;
  localparam int unsigned StEuler   = 0;
  localparam int unsigned StBounce  = 3;
  localparam int unsigned StScale   = 8;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegTimeStep   = 3'd0,
    RegNormalX    = 3'd1,
    RegNormalY    = 3'd2,
    RegNormalZ    = 3'd3,
    RegWallOffset = 3'd4,
    RegWallEnable = 3'd5
  } cfg_reg_e;

  localparam logic [23:0] ResetTimeStep  = 24'd1092;
  localparam norm_t       ResetNormalX   = 18'sd0;
  localparam norm_t       ResetNormalY   = 18'sd65536;
  localparam norm_t       ResetNormalZ   = 18'sd0;
  localparam q16_t        ResetWallOfs   = 32'sd32768;
  localparam logic        ResetWallEn    = 1'b0;

  localparam logic [56:0] BounceRound = 57'd163840;
  localparam logic [33:0] BounceTSat  = 34'd10737418245;
  localparam logic [34:0] Recip5      = 35'd27487790695;

  typedef struct packed {
    logic [23:0] time_step;
    norm_t       normal_x;
    norm_t       normal_y;
    norm_t       normal_z;
    q16_t        wall_offset;
    logic        wall_enable;
  } cfg_t;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctl_t;

  function automatic q16_t sat32(input logic signed [63:0] v);
    q16_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Divide by 2^16, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + 64'd32768) >> 16;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

### hdl/pes_pipe_ctrl.sv
// ============================================================================
// Pipeline control
// Valid bits for every stage and the per-stage load enables. A stage loads
// when it is empty or when the stage after it moves, so bubbles close up.
// ============================================================================
`include "particle_euler_step_with_plane_bounce_macros.svh"

module pes_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pes_pkg::pipe_ctl_t  ctl_o
);

  localparam int unsigned N = pes_pkg::NumStages;

  logic [N-1:0] vld_q, vld_d, en;

  always_comb begin
    en[N-1] = !vld_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < N; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl_o.en    = en;
  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[N-1];

  `PES_ASSERT(a_req_enters, in_valid_i && !in_stall_o |=> vld_q[0],
              "accepted request did not enter the first stage")
  `PES_ASSERT_NEVER(a_stall_only_full, in_stall_o && !(&vld_q),
                    "input stalled while a stage was empty")
  `PES_ASSERT(a_held_stays, (vld_q & $past(vld_q & ~en)) == $past(vld_q & ~en),
              "a held stage lost its request")

endmodule

### hdl/pes_euler.sv
// ============================================================================
// Euler step stages
// Three stages: products with the time step, the force terms and the new
// position, then the new velocity and the position terms of the wall test.
// ============================================================================
module pes_euler (
  input  logic               clk_i,
  input  pes_pkg::pipe_ctl_t ctl_i,
  input  pes_pkg::cfg_t      cfg_i,
  input  pes_pkg::q16_t      pos_i   [3],
  input  pes_pkg::q16_t      vel_i   [3],
  input  pes_pkg::q16_t      force_i [3],
  input  logic [31:0]        inv_mass_i,
  output pes_pkg::q16_t      x_o     [3],
  output pes_pkg::q16_t      np_o    [3],
  output pes_pkg::q16_t      nv_o    [3],
  output pes_pkg::prod_t     pn_o    [3]
);

  localparam int unsigned S0 = pes_pkg::StEuler;
  localparam int unsigned S1 = pes_pkg::StEuler + 1;
  localparam int unsigned S2 = pes_pkg::StEuler + 2;

  pes_pkg::norm_t nrm [3];

  logic [55:0]        idt_d, idt0_q;
  logic signed [55:0] vdt_d [3], vdt0_q [3];
  logic [31:0]        fm_d [3], fm0_q [3];
  logic               fneg0_q [3];
  pes_pkg::q16_t      x0_q [3], v0_q [3];

  logic [55:0]        fmh_d [3], fmh1_q [3];
  logic [63:0]        fml_d [3], fml1_q [3];
  pes_pkg::q16_t      np_d [3], np1_q [3];
  pes_pkg::q16_t      x1_q [3], v1_q [3];
  logic               fneg1_q [3];

  logic [63:0]        dm [3];
  logic signed [63:0] dms [3];
  pes_pkg::q16_t      nv_d [3], nv2_q [3];
  pes_pkg::prod_t     pn_d [3], pn2_q [3];
  pes_pkg::q16_t      x2_q [3], np2_q [3];

  assign nrm[0] = cfg_i.normal_x;
  assign nrm[1] = cfg_i.normal_y;
  assign nrm[2] = cfg_i.normal_z;

  always_comb begin
    idt_d = 56'(inv_mass_i) * 56'(cfg_i.time_step);
    for (int i = 0; i < 3; i++) begin
      vdt_d[i] = 56'(vel_i[i]) * $signed(56'(cfg_i.time_step));
      fm_d[i]  = force_i[i][31] ? 32'(-force_i[i]) : 32'(force_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S0]) begin
      idt0_q <= idt_d;
      for (int i = 0; i < 3; i++) begin
        vdt0_q[i]  <= vdt_d[i];
        fm0_q[i]   <= fm_d[i];
        fneg0_q[i] <= force_i[i][31];
        x0_q[i]    <= pos_i[i];
        v0_q[i]    <= vel_i[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fmh_d[i] = 56'(fm0_q[i]) * 56'(idt0_q[55:32]);
      fml_d[i] = 64'(fm0_q[i]) * 64'(idt0_q[31:0]);
      np_d[i]  = pes_pkg::sat32(64'(x0_q[i]) + pes_pkg::rnd16(64'(vdt0_q[i])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S1]) begin
      for (int i = 0; i < 3; i++) begin
        fmh1_q[i]  <= fmh_d[i];
        fml1_q[i]  <= fml_d[i];
        np1_q[i]   <= np_d[i];
        x1_q[i]    <= x0_q[i];
        v1_q[i]    <= v0_q[i];
        fneg1_q[i] <= fneg0_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dm[i]   = 64'(fmh1_q[i]) + ((fml1_q[i] + 64'h8000_0000) >> 32);
      dms[i]  = fneg1_q[i] ? -$signed(dm[i]) : $signed(dm[i]);
      nv_d[i] = pes_pkg::sat32(64'(v1_q[i]) + dms[i]);
      pn_d[i] = 50'(nrm[i]) * 50'(np1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S2]) begin
      for (int i = 0; i < 3; i++) begin
        nv2_q[i] <= nv_d[i];
        pn2_q[i] <= pn_d[i];
        x2_q[i]  <= x1_q[i];
        np2_q[i] <= np1_q[i];
      end
    end
  end

  assign x_o  = x2_q;
  assign np_o = np2_q;
  assign nv_o = nv2_q;
  assign pn_o = pn2_q;

endmodule

### hdl/pes_bounce.sv
// ============================================================================
// Wall test and reflection stages
// Five stages: wall side test and velocity projections, the dot product,
// its rounding, the normal scaling and the reflected velocity before the
// final 0.8 factor.
// ============================================================================
module pes_bounce (
  input  logic                clk_i,
  input  pes_pkg::pipe_ctl_t  ctl_i,
  input  pes_pkg::cfg_t       cfg_i,
  input  pes_pkg::q16_t       x_i   [3],
  input  pes_pkg::q16_t       np_i  [3],
  input  pes_pkg::q16_t       nv_i  [3],
  input  pes_pkg::prod_t      pn_i  [3],
  output logic                hit_o,
  output pes_pkg::q16_t       pos_o [3],
  output pes_pkg::q16_t       nv_o  [3],
  output logic signed [54:0]  r_o   [3]
);

  localparam int unsigned S3 = pes_pkg::StBounce;
  localparam int unsigned S4 = pes_pkg::StBounce + 1;
  localparam int unsigned S5 = pes_pkg::StBounce + 2;
  localparam int unsigned S6 = pes_pkg::StBounce + 3;
  localparam int unsigned S7 = pes_pkg::StBounce + 4;

  pes_pkg::norm_t nrm [3];

  logic signed [51:0] side;
  logic               hit_d, hit3_q, hit4_q, hit5_q, hit6_q, hit7_q;
  pes_pkg::prod_t     vn_d [3], vn3_q [3];
  pes_pkg::q16_t      x3_q [3], np3_q [3], nv3_q [3];

  logic signed [51:0] dot_d, dot4_q;
  pes_pkg::q16_t      x4_q [3], np4_q [3], nv4_q [3];

  logic signed [35:0] q_d, q5_q;
  pes_pkg::q16_t      x5_q [3], np5_q [3], nv5_q [3];

  logic signed [53:0] qn_d [3], qn6_q [3];
  pes_pkg::q16_t      x6_q [3], np6_q [3], nv6_q [3];

  logic signed [54:0] r_d [3], r7_q [3];
  pes_pkg::q16_t      pos7_q [3], nv7_q [3];

  assign nrm[0] = cfg_i.normal_x;
  assign nrm[1] = cfg_i.normal_y;
  assign nrm[2] = cfg_i.normal_z;

  always_comb begin
    side  = 52'(pn_i[0]) + 52'(pn_i[1]) + 52'(pn_i[2]) + (52'(cfg_i.wall_offset) <<< 16);
    hit_d = cfg_i.wall_enable & side[51];
    for (int i = 0; i < 3; i++) begin
      vn_d[i] = 50'(nrm[i]) * 50'(nv_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S3]) begin
      hit3_q <= hit_d;
      for (int i = 0; i < 3; i++) begin
        vn3_q[i] <= vn_d[i];
        x3_q[i]  <= x_i[i];
        np3_q[i] <= np_i[i];
        nv3_q[i] <= nv_i[i];
      end
    end
  end

  assign dot_d = 52'(vn3_q[0]) + 52'(vn3_q[1]) + 52'(vn3_q[2]);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S4]) begin
      dot4_q <= dot_d;
      hit4_q <= hit3_q;
      x4_q   <= x3_q;
      np4_q  <= np3_q;
      nv4_q  <= nv3_q;
    end
  end

  assign q_d = 36'(pes_pkg::rnd16(64'(dot4_q)));

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S5]) begin
      q5_q   <= q_d;
      hit5_q <= hit4_q;
      x5_q   <= x4_q;
      np5_q  <= np4_q;
      nv5_q  <= nv4_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qn_d[i] = 54'(q5_q) * 54'(nrm[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S6]) begin
      qn6_q  <= qn_d;
      hit6_q <= hit5_q;
      x6_q   <= x5_q;
      np6_q  <= np5_q;
      nv6_q  <= nv5_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_d[i] = (55'(nv6_q[i]) <<< 16) - (55'(qn6_q[i]) <<< 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S7]) begin
      hit7_q <= hit6_q;
      r7_q   <= r_d;
      nv7_q  <= nv6_q;
      for (int i = 0; i < 3; i++) begin
        pos7_q[i] <= hit6_q ? x6_q[i] : np6_q[i];
      end
    end
  end

  assign hit_o = hit7_q;
  assign pos_o = pos7_q;
  assign nv_o  = nv7_q;
  assign r_o   = r7_q;

endmodule

### hdl/pes_scale.sv
// ============================================================================
// Bounce scaling and output stages
// Three stages apply the exact 0.8 factor with rounding: the scaled magnitude
// is formed and clamped, divided by five through a split reciprocal product,
// then signed, saturated and selected into the output registers.
// ============================================================================
module pes_scale (
  input  logic                clk_i,
  input  pes_pkg::pipe_ctl_t  ctl_i,
  input  logic                hit_i,
  input  pes_pkg::q16_t       pos_i [3],
  input  pes_pkg::q16_t       nv_i  [3],
  input  logic signed [54:0]  r_i   [3],
  output logic                hit_o,
  output pes_pkg::q16_t       pos_o [3],
  output pes_pkg::q16_t       vel_o [3]
);

  localparam int unsigned S8  = pes_pkg::StScale;
  localparam int unsigned S9  = pes_pkg::StScale + 1;
  localparam int unsigned S10 = pes_pkg::StScale + 2;

  logic [56:0]   u [3];
  logic [40:0]   t_full [3];
  logic [33:0]   t_d [3], t8_q [3];
  logic          neg8_q [3], neg9_q [3];
  logic          hit8_q, hit9_q, hit10_q;
  pes_pkg::q16_t pos8_q [3], nv8_q [3], pos9_q [3], nv9_q [3];

  logic [51:0]   pph_d [3], ppl_d [3], pph9_q [3], ppl9_q [3];

  logic [68:0]        prod [3];
  logic [31:0]        mq [3];
  logic signed [63:0] vb [3];
  pes_pkg::q16_t      vel_d [3], vel10_q [3], pos10_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (r_i[i][54]) begin
        u[i] = pes_pkg::BounceRound - 57'(r_i[i] <<< 2);
      end else begin
        u[i] = pes_pkg::BounceRound + 57'(r_i[i] <<< 2);
      end
      t_full[i] = u[i][56:16];
      t_d[i]    = (t_full[i] >= 41'(pes_pkg::BounceTSat)) ? pes_pkg::BounceTSat
                                                          : t_full[i][33:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S8]) begin
      hit8_q <= hit_i;
      pos8_q <= pos_i;
      nv8_q  <= nv_i;
      t8_q   <= t_d;
      for (int i = 0; i < 3; i++) begin
        neg8_q[i] <= r_i[i][54];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pph_d[i] = 52'(t8_q[i][33:17]) * 52'(pes_pkg::Recip5);
      ppl_d[i] = 52'(t8_q[i][16:0]) * 52'(pes_pkg::Recip5);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S9]) begin
      hit9_q <= hit8_q;
      pos9_q <= pos8_q;
      nv9_q  <= nv8_q;
      neg9_q <= neg8_q;
      pph9_q <= pph_d;
      ppl9_q <= ppl_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]  = (69'(pph9_q[i]) << 17) + 69'(ppl9_q[i]);
      mq[i]    = prod[i][68:37];
      vb[i]    = neg9_q[i] ? -$signed(64'(mq[i])) : $signed(64'(mq[i]));
      vel_d[i] = hit9_q ? pes_pkg::sat32(vb[i]) : nv9_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[S10]) begin
      hit10_q <= hit9_q;
      pos10_q <= pos9_q;
      vel10_q <= vel_d;
    end
  end

  assign hit_o = hit10_q;
  assign pos_o = pos10_q;
  assign vel_o = vel10_q;

endmodule

### hdl/particle_euler_step_with_plane_bounce.sv
// ============================================================================
// Particle Euler step with plane bounce
// One request carries a particle's position, velocity, summed force and
// inverse mass in Q16.16. The result is the particle after one explicit
// Euler step, bounced off the enabled wall when it ends up behind the wall.
// Input and output channels use valid and stall; a request moves on a clock
// edge where valid is high and stall is low. The user must write registers
// through cfg_we_i, cfg_idx_i and cfg_data_i while no request is in flight;
// the block does not enforce this. The datapath has eleven register stages
// (multipliers, the wall dot products and the divide by five). One request
// is accepted per cycle while the input is not stalled. When the output is
// stalled, results stay in their stages and empty stages keep filling; the
// input stalls only when all eleven stages hold a request.
// Reset clears all valid bits and loads the register reset values.
// ============================================================================
module particle_euler_step_with_plane_bounce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pes_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pes_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            pos_z_i,
  input  logic signed [31:0]            vel_x_i,
  input  logic signed [31:0]            vel_y_i,
  input  logic signed [31:0]            vel_z_i,
  input  logic signed [31:0]            force_x_i,
  input  logic signed [31:0]            force_y_i,
  input  logic signed [31:0]            force_z_i,
  input  logic [31:0]                   inv_mass_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            new_pos_x_o,
  output logic signed [31:0]            new_pos_y_o,
  output logic signed [31:0]            new_pos_z_o,
  output logic signed [31:0]            new_vel_x_o,
  output logic signed [31:0]            new_vel_y_o,
  output logic signed [31:0]            new_vel_z_o,
  output logic                          wall_hit_o
);

  logic [23:0]    time_step_q;
  pes_pkg::norm_t normal_x_q, normal_y_q, normal_z_q;
  pes_pkg::q16_t  wall_offset_q;
  logic           wall_enable_q;

  pes_pkg::cfg_t      cfg;
  pes_pkg::pipe_ctl_t ctl;

  pes_pkg::q16_t  pos [3], vel [3], frc [3];
  pes_pkg::q16_t  eu_x [3], eu_np [3], eu_nv [3];
  pes_pkg::prod_t eu_pn [3];

  logic               bo_hit;
  pes_pkg::q16_t      bo_pos [3], bo_nv [3];
  logic signed [54:0] bo_r [3];

  pes_pkg::q16_t res_pos [3], res_vel [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q   <= pes_pkg::ResetTimeStep;
      normal_x_q    <= pes_pkg::ResetNormalX;
      normal_y_q    <= pes_pkg::ResetNormalY;
      normal_z_q    <= pes_pkg::ResetNormalZ;
      wall_offset_q <= pes_pkg::ResetWallOfs;
      wall_enable_q <= pes_pkg::ResetWallEn;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pes_pkg::RegTimeStep:   time_step_q   <= cfg_data_i[23:0];
        pes_pkg::RegNormalX:    normal_x_q    <= cfg_data_i[17:0];
        pes_pkg::RegNormalY:    normal_y_q    <= cfg_data_i[17:0];
        pes_pkg::RegNormalZ:    normal_z_q    <= cfg_data_i[17:0];
        pes_pkg::RegWallOffset: wall_offset_q <= cfg_data_i[31:0];
        pes_pkg::RegWallEnable: wall_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg.time_step   = time_step_q;
  assign cfg.normal_x    = normal_x_q;
  assign cfg.normal_y    = normal_y_q;
  assign cfg.normal_z    = normal_z_q;
  assign cfg.wall_offset = wall_offset_q;
  assign cfg.wall_enable = wall_enable_q;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;
  assign vel[0] = vel_x_i;
  assign vel[1] = vel_y_i;
  assign vel[2] = vel_z_i;
  assign frc[0] = force_x_i;
  assign frc[1] = force_y_i;
  assign frc[2] = force_z_i;

  pes_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  pes_euler u_euler (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .cfg_i      (cfg),
    .pos_i      (pos),
    .vel_i      (vel),
    .force_i    (frc),
    .inv_mass_i (inv_mass_i),
    .x_o        (eu_x),
    .np_o       (eu_np),
    .nv_o       (eu_nv),
    .pn_o       (eu_pn)
  );

  pes_bounce u_bounce (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .cfg_i (cfg),
    .x_i   (eu_x),
    .np_i  (eu_np),
    .nv_i  (eu_nv),
    .pn_i  (eu_pn),
    .hit_o (bo_hit),
    .pos_o (bo_pos),
    .nv_o  (bo_nv),
    .r_o   (bo_r)
  );

  pes_scale u_scale (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .hit_i (bo_hit),
    .pos_i (bo_pos),
    .nv_i  (bo_nv),
    .r_i   (bo_r),
    .hit_o (wall_hit_o),
    .pos_o (res_pos),
    .vel_o (res_vel)
  );

  assign new_pos_x_o = res_pos[0];
  assign new_pos_y_o = res_pos[1];
  assign new_pos_z_o = res_pos[2];
  assign new_vel_x_o = res_vel[0];
  assign new_vel_y_o = res_vel[1];
  assign new_vel_z_o = res_vel[2];

endmodule
